// ===== rtl/core/mf3_pkg.sv =====
// Package for the 3x3 median filter: widths, register map, control structs
// and the min/max/median-of-three helpers used by the median datapath.
// No dependencies.
`timescale 1ns / 1ps

package mf3_pkg;

    // pixel and register widths
    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 12;

    // default storage size and height limit
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_USED = 4095;
    localparam int MIN_DIM         = 3;

    // reset values of the configuration registers
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd720;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // apb register map
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // one pixel step entering the median datapath
    typedef struct packed {
        logic valid;
        logic emit;
        logic done;
    } t_step;

    // control of a result moving down the median pipeline
    typedef struct packed {
        logic valid;
        logic done;
    } t_res;

    function automatic logic [PIX_W-1:0] f_min(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] f_max(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] f_med3(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

endpackage

// ===== rtl/core/mf3_if.sv =====
// Stream interfaces of the 3x3 median filter: pixel requests in, medians out.
// Depends on mf3_pkg for the payload widths.
`timescale 1ns / 1ps

interface mf3_in_if;
    logic                      valid;
    logic                      ready;
    logic [mf3_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3_out_if;
    logic                      valid;
    logic                      ready;
    logic [mf3_pkg::PIX_W-1:0] median_out;
    logic                      frame_done;

    modport source (output valid, output median_out, output frame_done, input ready);
    modport sink   (input valid, input median_out, input frame_done, output ready);
endinterface

// ===== rtl/core/mf3_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mf3_median.sv =====
// Median-of-nine network: sorts each new column, keeps the 3-column window
// and reduces it to one median over three register stages. Uses mf3_pkg.
`timescale 1ns / 1ps

module mf3_median (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mf3_pkg::t_step            i_step,
    input  logic [mf3_pkg::PIX_W-1:0] i_top,
    input  logic [mf3_pkg::PIX_W-1:0] i_mid,
    input  logic [mf3_pkg::PIX_W-1:0] i_pix,
    output mf3_pkg::t_res             o_res,
    output logic [mf3_pkg::PIX_W-1:0] o_median
);

    localparam int PW = mf3_pkg::PIX_W;

    logic [PW-1:0] col_lo;
    logic [PW-1:0] col_md;
    logic [PW-1:0] col_hi;

    // window, index 0 is the oldest column
    logic [PW-1:0] r_win_lo [3];
    logic [PW-1:0] r_win_md [3];
    logic [PW-1:0] r_win_hi [3];
    mf3_pkg::t_res r_b;

    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_md;
    logic [PW-1:0] r_hi;
    mf3_pkg::t_res r_c;

    logic [PW-1:0] r_med;
    mf3_pkg::t_res r_d;

    // sort the incoming column
    always_comb begin
        col_lo = mf3_pkg::f_min(i_top, mf3_pkg::f_min(i_mid, i_pix));
        col_md = mf3_pkg::f_med3(i_top, i_mid, i_pix);
        col_hi = mf3_pkg::f_max(i_top, mf3_pkg::f_max(i_mid, i_pix));
    end

    // shift window on every pixel step
    always_ff @(posedge i_clk) begin
        if (i_step.valid) begin
            r_win_lo[0] <= r_win_lo[1];
            r_win_lo[1] <= r_win_lo[2];
            r_win_lo[2] <= col_lo;
            r_win_md[0] <= r_win_md[1];
            r_win_md[1] <= r_win_md[2];
            r_win_md[2] <= col_md;
            r_win_hi[0] <= r_win_hi[1];
            r_win_hi[1] <= r_win_hi[2];
            r_win_hi[2] <= col_hi;
        end
    end

    // reduce window to three candidates, then the final median
    always_ff @(posedge i_clk) begin
        r_lo  <= mf3_pkg::f_max(r_win_lo[0], mf3_pkg::f_max(r_win_lo[1], r_win_lo[2]));
        r_md  <= mf3_pkg::f_med3(r_win_md[0], r_win_md[1], r_win_md[2]);
        r_hi  <= mf3_pkg::f_min(r_win_hi[0], mf3_pkg::f_min(r_win_hi[1], r_win_hi[2]));
        r_med <= mf3_pkg::f_med3(r_lo, r_md, r_hi);
    end

    // control pipeline, only interior pixels carry a valid result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else begin
            r_b.valid <= i_step.valid && i_step.emit;
            r_b.done  <= i_step.done;
            r_c       <= r_b;
            r_d       <= r_c;
        end
    end

    assign o_res    = r_d;
    assign o_median = r_med;

endmodule

// ===== rtl/core/median_filter_3x3.sv =====
// 3x3 median filter. An accepted request passes the first stage (line store
// read), the median network and the output queue. Throughput: one pixel per
// clock while input ready is high, one line store read and one write-back per
// cycle. After reset each line store address is cleared with input ready low;
// configuration writes are taken throughout. Registers reset to width 720 and height 480.
`timescale 1ns / 1ps

module median_filter_3x3 #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mf3_in_if.sink                     i_pix,
    mf3_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mf3_pkg::APB_AW-1:0] paddr,
    input  logic [mf3_pkg::APB_DW-1:0] pwdata,
    output logic [mf3_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int PW   = mf3_pkg::PIX_W;
    localparam int FWW  = mf3_pkg::FRAME_WIDTH_W;
    localparam int FHW  = mf3_pkg::FRAME_HEIGHT_W;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WMW  = $clog2(MAX_WIDTH + 1);
    localparam int WCMP = (WMW > FWW) ? WMW : FWW;
    localparam int QAW  = mf3_pkg::FIFO_AW;
    localparam int QD   = mf3_pkg::FIFO_DEPTH;

    // configuration registers
    logic [FWW-1:0] r_frame_width;
    logic [FHW-1:0] r_frame_height;
    logic [mf3_pkg::REG_IDX_W-1:0] reg_idx;
    logic cfg_wr;

    // position counters
    logic [CW-1:0]  r_col;
    logic [FHW-1:0] r_row;
    logic [CW-1:0]  n_col;
    logic [FHW-1:0] n_row;

    // clamped frame size
    logic [WCMP-1:0] fw_ext;
    logic [WCMP-1:0] w_use;
    logic [WCMP-1:0] w_last;
    logic [FHW-1:0]  h_last;
    logic col_end;
    logic row_end;
    logic emit;

    // clearing pass
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;

    // first stage, line store read in flight
    logic           accept;
    mf3_pkg::t_step r_s1;
    logic [PW-1:0]  r_s1_pix;
    logic [CW-1:0]  r_s1_addr;

    // line store port
    logic            ram_we;
    logic [CW-1:0]   ram_waddr;
    logic [2*PW-1:0] ram_wdata;
    logic [2*PW-1:0] ram_rdata;
    logic [PW-1:0]   top_pix;
    logic [PW-1:0]   mid_pix;

    // median datapath result
    mf3_pkg::t_res med_res;
    logic [PW-1:0] med_val;

    // output queue and credit
    logic [PW-1:0]  r_q_med  [QD];
    logic           r_q_done [QD];
    logic [QAW-1:0] r_q_wptr;
    logic [QAW-1:0] r_q_rptr;
    logic [QAW:0]   r_q_cnt;
    logic [QAW:0]   r_credit;
    logic [QAW:0]   n_credit;
    logic           q_push;
    logic           q_pop;

    // apb register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[mf3_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3_pkg::FRAME_WIDTH_RST;
            r_frame_height <= mf3_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                mf3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FWW-1:0];
                mf3_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[FHW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mf3_pkg::REG_FRAME_WIDTH:  prdata = {{(mf3_pkg::APB_DW-FWW){1'b0}}, r_frame_width};
            mf3_pkg::REG_FRAME_HEIGHT: prdata = {{(mf3_pkg::APB_DW-FHW){1'b0}}, r_frame_height};
            default:                   prdata = '0;
        endcase
    end

    // clamp frame size and find the row and frame ends
    always_comb begin
        fw_ext = WCMP'(r_frame_width);
        if (fw_ext < WCMP'(mf3_pkg::MIN_DIM)) begin
            w_use = WCMP'(mf3_pkg::MIN_DIM);
        end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
            w_use = WCMP'(MAX_WIDTH);
        end else begin
            w_use = fw_ext;
        end
        w_last = w_use - WCMP'(1);
        if (r_frame_height < FHW'(mf3_pkg::MIN_DIM)) begin
            h_last = FHW'(mf3_pkg::MIN_DIM - 1);
        end else begin
            h_last = r_frame_height - FHW'(1);
        end
        col_end = WCMP'(r_col) >= w_last;
        row_end = r_row >= h_last;
        emit    = (r_row >= FHW'(2)) && (r_col >= CW'(2));
    end

    // input handshake, held off by clearing and by a full output credit
    assign i_pix.ready = !r_clr_busy && (r_credit != (QAW + 1)'(QD));
    assign accept      = i_pix.valid && i_pix.ready;

    // position counter update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + FHW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // clearing pass over the line store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // first stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.valid <= accept;
            r_s1.emit  <= emit;
            r_s1.done  <= row_end && col_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_pix.pixel_in;
        r_s1_addr <= r_col;
    end

    // line store: upper byte is two rows up, lower byte one row up
    assign top_pix = ram_rdata[2*PW-1:PW];
    assign mid_pix = ram_rdata[PW-1:0];

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_s1.valid;
            ram_waddr = r_s1_addr;
            ram_wdata = {mid_pix, r_s1_pix};
        end
    end

    mf3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    mf3_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_s1),
        .i_top    (top_pix),
        .i_mid    (mid_pix),
        .i_pix    (r_s1_pix),
        .o_res    (med_res),
        .o_median (med_val)
    );

    // output queue
    assign q_push = med_res.valid;
    assign q_pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_med[r_q_wptr]  <= med_val;
            r_q_done[r_q_wptr] <= med_res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wptr <= '0;
            r_q_rptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (q_push) begin
                r_q_wptr <= r_q_wptr + QAW'(1);
            end
            if (q_pop) begin
                r_q_rptr <= r_q_rptr + QAW'(1);
            end
            case ({q_push, q_pop})
                2'b10:   r_q_cnt <= r_q_cnt + (QAW + 1)'(1);
                2'b01:   r_q_cnt <= r_q_cnt - (QAW + 1)'(1);
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    // credit counts interior requests accepted and not yet delivered
    always_comb begin
        case ({accept && emit, q_pop})
            2'b10:   n_credit = r_credit + (QAW + 1)'(1);
            2'b01:   n_credit = r_credit - (QAW + 1)'(1);
            default: n_credit = r_credit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    assign o_res.valid      = r_q_cnt != '0;
    assign o_res.median_out = r_q_med[r_q_rptr];
    assign o_res.frame_done = r_q_done[r_q_rptr];

endmodule

// ===== rtl/core/mf3_checker.sv =====
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and on the median_filter_3x3 ports.
`timescale 1ns / 1ps

module mf3_port_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [mf3_pkg::PIX_W-1:0] i_median,
    input logic                      i_done
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_median) && $stable(i_done))
        else $error("stalled result changed");

    // no request taken in the first cycle after reset, the line store is clearing
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("request taken during line store clear");

    // a result appearing on an empty output traces back to an accepted request
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 5))
        else $error("result without matching request");

endmodule

bind median_filter_3x3 mf3_port_checker u_mf3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_median    (o_res.median_out),
    .i_done      (o_res.frame_done)
);
